### rtl/tapid_pkg.sv
// Package with the shared types, widths, register codes and reset values of the two-axis PID.
`default_nettype none

package tapid_pkg;

    // Default number of axes handled by one block.
    localparam int NUM_AXES_DEF = 2;

    // Field widths.
    localparam int COUNT_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int ERR_W     = COUNT_W + 1;
    localparam int ACC_W     = 32;
    localparam int DERIV_W   = ERR_W + 1;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // Product and sum widths (gains are zero-extended to signed).
    localparam int PPROD_W = GAIN_W + 1 + ERR_W;
    localparam int IPROD_W = GAIN_W + 1 + ACC_W;
    localparam int DPROD_W = GAIN_W + 1 + DERIV_W;
    localparam int SUM_W   = IPROD_W + 2;
    localparam int FRAC_W  = 8;
    localparam int QUO_W   = SUM_W - FRAC_W;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 8'd0,
        CFG_INTEG_GAIN = 8'd1,
        CFG_DERIV_GAIN = 8'd2,
        CFG_DEADBAND   = 8'd3
    } cfg_idx_t;

    // Register reset values.
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd2048;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd0;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd267;
    localparam logic [GAIN_W-1:0] DEADBAND_RST   = 16'd100;

    // Signed 32-bit limits.
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [DERIV_W-1:0] deriv_t;

    // Per-axis state word kept in the state memory.
    typedef struct packed {
        acc_t integ;
        err_t prev_err;
    } axis_state_t;

    localparam int STATE_W = $bits(axis_state_t);

endpackage

`default_nettype wire

### rtl/tapid_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tapid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/two_axis_pid_with_deadband.sv
// Two-axis PID position controller with a symmetric deadband, per-axis state in RAM.
`default_nettype none

// Each accepted item is one control tick for one axis. The error is
// target_count - measured_count; when its magnitude is below the deadband the
// result is drive 0, active 0 and the axis state is left alone, otherwise the
// saturating integral and the derivative are updated and the Q8.8 weighted sum,
// floored by 256 and saturated to 32 bits, is returned with active 1. The block
// takes one item per cycle unless stalled, also for consecutive ticks of the
// same axis, and returns results in order. That rate is set by the per-axis
// state memory's read-modify-write loop: one read at acceptance, one write on
// leaving stage 1, closed by a one-entry bypass. The state memory comes out of
// reset cleared through per-axis valid bits, so there is no clearing pass.
// Configuration writes are always accepted and must only be issued while no
// item is in flight; register indexes beyond the list are ignored.

module two_axis_pid_with_deadband
    import tapid_pkg::*;
#(
    parameter int NUM_AXES = NUM_AXES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [COUNT_W-1:0]   s_target_count,
    input  wire logic [COUNT_W-1:0]   s_measured_count,
    input  wire logic                 s_axis_sel,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [ACC_W-1:0]   m_drive,
    output logic                      m_active
);

    localparam int AX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    // Configuration registers.
    logic [GAIN_W-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg, deadband_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            deadband_reg   <= DEADBAND_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                CFG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                CFG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                CFG_DEADBAND:   deadband_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline valid flags and the ready chain; a stage loads when it is empty
    // or its item moves on in the same cycle.
    logic v1_reg, v2_reg, v3_reg;
    logic adv_out, ok3, ok2, ok1, rd_en;

    assign adv_out = !m_valid || m_ready;
    assign ok3     = !v3_reg || adv_out;
    assign ok2     = !v2_reg || ok3;
    assign ok1     = !v1_reg || ok2;
    assign s_ready = ok1;
    assign rd_en   = s_valid && s_ready;

    // Front end: error, deadband test and axis selection at acceptance.
    err_t             err_next;
    logic [ERR_W-1:0] mag_next;
    logic             act_next;
    logic [AX_W-1:0]  ax_idx;

    always_comb begin
        err_next = $signed({1'b0, s_target_count}) - $signed({1'b0, s_measured_count});
        mag_next = err_next[ERR_W-1] ? ERR_W'(-err_next) : ERR_W'(err_next);
        act_next = mag_next >= ERR_W'(deadband_reg);
        if (AX_W'(s_axis_sel) >= AX_W'(NUM_AXES - 1)) begin
            ax_idx = AX_W'(NUM_AXES - 1);
        end else begin
            ax_idx = AX_W'(s_axis_sel);
        end
    end

    // State memory, its per-axis valid bits and the write from stage 1.
    logic                st_we;
    axis_state_t         st_wdata, st_rdata;
    logic [NUM_AXES-1:0] vld_reg;
    logic [AX_W-1:0]     ax1_reg;

    tapid_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_AXES)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (st_we),
        .wr_addr (ax1_reg),
        .wr_data (st_wdata),
        .rd_en   (rd_en),
        .rd_addr (ax_idx),
        .rd_data (st_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (st_we) begin
            vld_reg[ax1_reg] <= 1'b1;
        end
    end

    // Stage 1 registers. A write at the same edge as the read is not seen by
    // the memory, so that write is captured here as a bypass.
    logic        act1_reg, vld1_reg, fwd1_reg;
    err_t        err1_reg;
    axis_state_t fwdd1_reg;
    logic        fwd_next;

    assign fwd_next = st_we && (ax1_reg == ax_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ok1) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            act1_reg  <= act_next;
            err1_reg  <= err_next;
            ax1_reg   <= ax_idx;
            vld1_reg  <= vld_reg[ax_idx];
            fwd1_reg  <= fwd_next;
            fwdd1_reg <= st_wdata;
        end
    end

    // Stage 1 logic: current state, saturating integral and derivative.
    axis_state_t            cur_state;
    logic signed [ACC_W:0]  isum;
    acc_t                   integ_next;
    deriv_t                 deriv_next;

    always_comb begin
        if (fwd1_reg) begin
            cur_state = fwdd1_reg;
        end else if (vld1_reg) begin
            cur_state = st_rdata;
        end else begin
            cur_state = '0;
        end
        isum = (ACC_W+1)'(cur_state.integ) + (ACC_W+1)'(err1_reg);
        if (isum[ACC_W] != isum[ACC_W-1]) begin
            integ_next = isum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            integ_next = isum[ACC_W-1:0];
        end
        deriv_next = DERIV_W'(err1_reg) - DERIV_W'(cur_state.prev_err);
        st_wdata.integ    = integ_next;
        st_wdata.prev_err = err1_reg;
    end

    assign st_we = v1_reg && ok2 && act1_reg;

    // Stage 2 registers.
    logic   act2_reg;
    err_t   err2_reg;
    acc_t   integ2_reg;
    deriv_t deriv2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ok2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg && ok2) begin
            act2_reg   <= act1_reg;
            err2_reg   <= err1_reg;
            integ2_reg <= integ_next;
            deriv2_reg <= deriv_next;
        end
    end

    // Stage 2 logic: the three gain products, each registered.
    logic signed [PPROD_W-1:0] pprod_next, pprod_reg;
    logic signed [IPROD_W-1:0] iprod_next, iprod_reg;
    logic signed [DPROD_W-1:0] dprod_next, dprod_reg;
    logic                      act3_reg;

    always_comb begin
        pprod_next = $signed({1'b0, prop_gain_reg}) * err2_reg;
        iprod_next = $signed({1'b0, integ_gain_reg}) * integ2_reg;
        dprod_next = $signed({1'b0, deriv_gain_reg}) * deriv2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ok3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && ok3) begin
            act3_reg  <= act2_reg;
            pprod_reg <= pprod_next;
            iprod_reg <= iprod_next;
            dprod_reg <= dprod_next;
        end
    end

    // Stage 3 logic: sum, floor by 256 and saturate to 32 bits.
    logic signed [SUM_W-1:0] sum;
    logic signed [QUO_W-1:0] quo;
    acc_t                    drive_next;

    always_comb begin
        sum = SUM_W'(pprod_reg) + SUM_W'(iprod_reg) + SUM_W'(dprod_reg);
        quo = sum[SUM_W-1:FRAC_W];
        if (!act3_reg) begin
            drive_next = '0;
        end else if (quo > QUO_W'(ACC_MAX)) begin
            drive_next = ACC_MAX;
        end else if (quo < QUO_W'(ACC_MIN)) begin
            drive_next = ACC_MIN;
        end else begin
            drive_next = quo[ACC_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (adv_out) begin
            m_valid <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v3_reg && adv_out) begin
            m_drive  <= drive_next;
            m_active <= act3_reg;
        end
    end

`ifndef SYNTHESIS
    // A result inside the deadband always carries a zero drive.
    a_inactive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_active) |-> (m_drive == '0))
        else $error("inactive result with nonzero drive");

    // A state write at the same edge as a read of that axis must be bypassed.
    a_bypass_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && st_we && (ax1_reg == ax_idx)) |=> fwd1_reg)
        else $error("same-axis write not forwarded");

    // A stalled last stage keeps its item.
    a_stage3_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !ok3) |=> v3_reg)
        else $error("stage 3 item lost under stall");

    // Input is refused only while every stage holds an item and the output is stalled.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && m_valid && !m_ready))
        else $error("input refused with a free stage");
`endif

endmodule

`default_nettype wire
